FILE: rtl/core/lwin_pkg.sv
// Shared types, character codes and token kinds for the lexer with identifier numbering.
// Used by every module under rtl/core except lwin_ram; depends on nothing else.
`timescale 1ns / 1ps

package lwin_pkg;

	// One input beat: a character byte and the end-of-stream mark.
	typedef struct packed {
		logic [7:0] char_code;
		logic       is_final;
	} char_beat_t;

	// One output beat: a token with its value and flags.
	typedef struct packed {
		logic [1:0]  token_kind;
		logic [30:0] token_value;
		logic        table_full;
		logic        end_of_run;
	} token_beat_t;

	localparam logic [1:0] KIND_SPEC  = 2'd0;
	localparam logic [1:0] KIND_CONST = 2'd1;
	localparam logic [1:0] KIND_IDENT = 2'd2;

	localparam logic [30:0] CONST_MAX = 31'h7FFF_FFFF;
	localparam logic [2:0]  OP_COUNT  = 3'd6;

	localparam logic [7:0] CH_ZERO    = 8'd48;
	localparam logic [7:0] CH_NINE    = 8'd57;
	localparam logic [7:0] CH_LET_LO  = 8'd65;
	localparam logic [7:0] CH_LET_HI  = 8'd122;
	localparam logic [7:0] CH_LPAREN  = 8'd40;
	localparam logic [7:0] CH_RPAREN  = 8'd41;
	localparam logic [7:0] CH_STAR    = 8'd42;
	localparam logic [7:0] CH_PLUS    = 8'd43;
	localparam logic [7:0] CH_MINUS   = 8'd45;
	localparam logic [7:0] CH_SLASH   = 8'd47;

	localparam logic [31:0] HASH_BASE   = 32'd37;
	localparam logic [31:0] LETTER_BIAS = 32'd66;

	// Depth of the token queue between front and back (power of two).
	localparam int QUEUE_DEPTH = 4;

	// Token command from the front: IDENT carries the full hash in data.
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] data;
		logic        last;
	} cmd_t;

	typedef struct packed {
		logic       valid;
		logic [2:0] idx;
	} op_t;

	// Operator index for + - * / ( ).
	function automatic op_t op_decode(input logic [7:0] ch);
		op_t r;
		r.valid = 1'b1;
		r.idx   = 3'd0;
		unique case (ch)
			CH_PLUS:   r.idx = 3'd0;
			CH_MINUS:  r.idx = 3'd1;
			CH_STAR:   r.idx = 3'd2;
			CH_SLASH:  r.idx = 3'd3;
			CH_LPAREN: r.idx = 3'd4;
			CH_RPAREN: r.idx = 3'd5;
			default:   r.valid = 1'b0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/lwin_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lwin_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/lwin_front.sv
// Scanner front: takes characters, tracks the pending constant or identifier, and
// pushes token commands into the queue. Depends on lwin_pkg.
`timescale 1ns / 1ps

module lwin_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    char_valid,
	output logic                    char_ready,
	input  lwin_pkg::char_beat_t    char_data,
	output logic                    q_push,
	output lwin_pkg::cmd_t          q_data,
	input  logic                    q_full
);

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'b001,
		MODE_NUM   = 3'b010,
		MODE_IDENT = 3'b100
	} mode_t;

	mode_t          mode_q, mode_d;
	logic [30:0]    num_q, num_d;
	logic [31:0]    hash_q, hash_d;
	logic [31:0]    weight_q, weight_d;
	logic           pend_valid_q;
	lwin_pkg::cmd_t pend_q;

	logic [7:0]     ch;
	logic [7:0]     dsub;
	logic [3:0]     dval;
	logic           dig, letter, fin, cont, fire;
	logic [31:0]    code, prod;
	logic [34:0]    num_wide;
	logic [30:0]    num_cont;
	logic [31:0]    hash_cont, weight_cont;
	lwin_pkg::op_t  op;
	logic           tok1_v, tok2_v;
	lwin_pkg::cmd_t tok1, tok2;

	assign ch     = char_data.char_code;
	assign fin    = char_data.is_final;
	assign dig    = (ch >= lwin_pkg::CH_ZERO) && (ch <= lwin_pkg::CH_NINE);
	assign letter = (ch >= lwin_pkg::CH_LET_LO) && (ch <= lwin_pkg::CH_LET_HI);
	assign dsub   = ch - lwin_pkg::CH_ZERO;
	assign dval   = dsub[3:0];
	assign op     = lwin_pkg::op_decode(ch);

	// Hash digit code wraps modulo 2^32 for letters below the bias.
	assign code = dig ? {28'b0, dval} : ({24'b0, ch} - lwin_pkg::LETTER_BIAS);
	assign prod = code * weight_q;
	assign hash_cont   = hash_q + prod;
	assign weight_cont = weight_q * lwin_pkg::HASH_BASE;

	// acc * 10 + digit, then saturate.
	assign num_wide = ({4'b0, num_q} << 3) + ({4'b0, num_q} << 1) + {31'b0, dval};
	assign num_cont = (num_wide > {4'b0, lwin_pkg::CONST_MAX}) ?
		lwin_pkg::CONST_MAX : num_wide[30:0];

	assign cont = ((mode_q == MODE_NUM) && dig) ||
		((mode_q == MODE_IDENT) && (dig || letter));

	always_comb begin
		mode_d   = mode_q;
		num_d    = num_q;
		hash_d   = hash_q;
		weight_d = weight_q;
		priority if (cont) begin
			if (mode_q == MODE_NUM) begin
				num_d = num_cont;
			end else begin
				hash_d   = hash_cont;
				weight_d = weight_cont;
			end
		end else if (dig) begin
			mode_d   = MODE_NUM;
			num_d    = {27'b0, dval};
			hash_d   = '0;
			weight_d = 32'd1;
		end else if (letter) begin
			mode_d   = MODE_IDENT;
			num_d    = '0;
			hash_d   = code;
			weight_d = lwin_pkg::HASH_BASE;
		end else begin
			mode_d   = MODE_IDLE;
			num_d    = '0;
			hash_d   = '0;
			weight_d = 32'd1;
		end
	end

	// First token: the one that this character ends.
	always_comb begin
		tok1_v    = !cont && (mode_q != MODE_IDLE);
		tok1.kind = (mode_q == MODE_NUM) ? lwin_pkg::KIND_CONST : lwin_pkg::KIND_IDENT;
		tok1.data = (mode_q == MODE_NUM) ? {1'b0, num_q} : hash_q;
		tok1.last = 1'b0;
	end

	// Second token: an operator, or the flush forced by the final mark.
	always_comb begin
		tok2_v    = 1'b0;
		tok2.kind = lwin_pkg::KIND_SPEC;
		tok2.data = {29'b0, op.idx};
		tok2.last = 1'b1;
		priority if (!cont && op.valid) begin
			tok2_v = 1'b1;
		end else if (fin && (mode_d == MODE_NUM)) begin
			tok2_v    = 1'b1;
			tok2.kind = lwin_pkg::KIND_CONST;
			tok2.data = {1'b0, num_d};
		end else if (fin && (mode_d == MODE_IDENT)) begin
			tok2_v    = 1'b1;
			tok2.kind = lwin_pkg::KIND_IDENT;
			tok2.data = hash_d;
		end else begin
			tok2_v = 1'b0;
		end
	end

	assign char_ready = !pend_valid_q && !q_full;
	assign fire       = char_valid && char_ready;

	always_comb begin
		if (pend_valid_q) begin
			q_push = !q_full;
			q_data = pend_q;
		end else begin
			q_push = fire && (tok1_v || tok2_v);
			q_data = tok1_v ?
				lwin_pkg::cmd_t'{kind: tok1.kind, data: tok1.data, last: !tok2_v} : tok2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			num_q        <= '0;
			hash_q       <= '0;
			weight_q     <= 32'd1;
			pend_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				if (fin) begin
					mode_q   <= MODE_IDLE;
					num_q    <= '0;
					hash_q   <= '0;
					weight_q <= 32'd1;
				end else begin
					mode_q   <= mode_d;
					num_q    <= num_d;
					hash_q   <= hash_d;
					weight_q <= weight_d;
				end
			end
			if (pend_valid_q) begin
				if (!q_full) begin
					pend_valid_q <= 1'b0;
				end
			end else if (fire && tok1_v && tok2_v) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	// Hold the second token of a two-token character.
	always_ff @(posedge clk) begin
		if (!pend_valid_q && fire && tok1_v && tok2_v) begin
			pend_q <= tok2;
		end
	end

endmodule

FILE: rtl/core/lwin_fifo.sv
// Short token-command queue between the scanner front and the lookup back.
// Depends on lwin_pkg for the command type and depth.
`timescale 1ns / 1ps

module lwin_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lwin_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output lwin_pkg::cmd_t pop_data,
	output logic           empty
);

	localparam int PW = $clog2(lwin_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(lwin_pkg::QUEUE_DEPTH + 1);

	lwin_pkg::cmd_t entry_q [lwin_pkg::QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  cnt_q;

	assign full     = (cnt_q == CW'(lwin_pkg::QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/core/lwin_back.sv
// Lookup back: turns token commands into result beats, numbering identifiers
// through a linear scan of the hash table RAM. Depends on lwin_pkg and lwin_ram.
`timescale 1ns / 1ps

module lwin_back #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  lwin_pkg::cmd_t        q_data,
	output logic                  q_pop,
	output logic                  tok_valid,
	input  logic                  tok_ready,
	output lwin_pkg::token_beat_t tok_data
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_EMIT = 3'b100
	} st_t;

	st_t                   st_q, st_d;
	logic [CW-1:0]         count_q;
	logic [IW-1:0]         idx_q;
	logic [31:0]           key_q;
	logic                  last_q;
	lwin_pkg::token_beat_t res_q, res_d;
	lwin_pkg::token_beat_t out_q, out_d;
	logic                  out_valid_q;

	logic          out_free, load_out, load_res, cnt_inc, start_scan;
	logic          ram_we, hit, at_end, new_ok;
	logic [IW-1:0] ram_raddr, ram_waddr;
	logic [31:0]   ram_wdata, ram_rdata;

	lwin_ram #(
		.WIDTH(32),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign out_free  = !out_valid_q || tok_ready;
	assign hit       = (ram_rdata == key_q);
	assign at_end    = ((CW'(idx_q) + CW'(1)) == count_q);
	assign new_ok    = (count_q != CW'(TABLE_DEPTH));
	assign ram_waddr = count_q[IW-1:0];
	assign ram_wdata = (st_q == ST_IDLE) ? q_data.data : key_q;
	// Entry 0 is read while idle, so its data is on the read port when a scan starts.
	assign ram_raddr = (st_q == ST_SCAN) ? (idx_q + IW'(1)) : '0;

	always_comb begin
		st_d       = st_q;
		q_pop      = 1'b0;
		ram_we     = 1'b0;
		load_out   = 1'b0;
		load_res   = 1'b0;
		cnt_inc    = 1'b0;
		start_scan = 1'b0;
		out_d      = res_q;
		res_d.token_kind  = lwin_pkg::KIND_IDENT;
		res_d.token_value = '0;
		res_d.table_full  = 1'b0;
		res_d.end_of_run  = last_q;
		unique case (st_q)
			ST_IDLE: begin
				if (!q_empty) begin
					if (q_data.kind != lwin_pkg::KIND_IDENT) begin
						if (out_free) begin
							q_pop    = 1'b1;
							load_out = 1'b1;
							out_d.token_kind  = q_data.kind;
							out_d.token_value = q_data.data[30:0];
							out_d.table_full  = 1'b0;
							out_d.end_of_run  = q_data.last;
						end
					end else begin
						q_pop = 1'b1;
						if (count_q == '0) begin
							ram_we   = 1'b1;
							cnt_inc  = 1'b1;
							load_res = 1'b1;
							res_d.end_of_run = q_data.last;
							st_d     = ST_EMIT;
						end else begin
							start_scan = 1'b1;
							st_d       = ST_SCAN;
						end
					end
				end
			end
			ST_SCAN: begin
				priority if (hit) begin
					load_res = 1'b1;
					res_d.token_value = 31'(idx_q);
					st_d     = ST_EMIT;
				end else if (at_end) begin
					load_res = 1'b1;
					if (new_ok) begin
						ram_we  = 1'b1;
						cnt_inc = 1'b1;
						res_d.token_value = 31'(count_q);
					end else begin
						res_d.table_full = 1'b1;
					end
					st_d = ST_EMIT;
				end else begin
					// Advance to the next stored entry.
					st_d = ST_SCAN;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cnt_inc) begin
				count_q <= count_q + CW'(1);
			end
			if (start_scan) begin
				idx_q <= '0;
			end else if (st_q == ST_SCAN) begin
				idx_q <= idx_q + IW'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (tok_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			key_q  <= q_data.data;
			last_q <= q_data.last;
		end
		if (load_res) begin
			res_q <= res_d;
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end

	assign tok_valid = out_valid_q;
	assign tok_data  = out_q;

endmodule

FILE: rtl/core/lexer_with_ident_numbering_unit.sv
// Lexer with identifier numbering: scanner front, token queue, lookup back.
// Path: an operator/constant token passes the queue and the output register; an identifier
// token also waits for the table scan, which reads entries until a hit or the last entry.
// Throughput: one beat per cycle while input is not stalled; a beat making two tokens holds
// input while the second waits, and the back is busy during each identifier scan, so a full 4-entry queue stalls input.
// Reset (arst_n low, async): scanner idle, queue empty, table count zero; no clearing pass.
`timescale 1ns / 1ps

module lexer_with_ident_numbering_unit #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_ready,
	input  lwin_pkg::char_beat_t  char_data,
	output logic                  tok_valid,
	input  logic                  tok_ready,
	output lwin_pkg::token_beat_t tok_data
);

	// Queue handshake between the front and the back.
	logic           q_push, q_full, q_pop, q_empty;
	lwin_pkg::cmd_t q_push_data, q_pop_data;

	// Front: accumulate constants and identifier hashes, one character a beat.
	// A character that ends a token and makes another pushes two commands; the
	// second waits in a holding register while input stalls.
	lwin_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_data (char_data),
		.q_push    (q_push),
		.q_data    (q_push_data),
		.q_full    (q_full)
	);

	// Queue: absorb the front while the back scans the table.
	lwin_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_push_data),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_pop_data),
		.empty    (q_empty)
	);

	// Back: pass operators and constants straight to the output register;
	// scan the hash table for identifiers and append new hashes.
	lwin_back #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (q_pop_data),
		.q_pop    (q_pop),
		.tok_valid(tok_valid),
		.tok_ready(tok_ready),
		.tok_data (tok_data)
	);

`ifndef SYNTHESIS
	// Front never pushes into a full queue.
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("token queue overflow");

	// Back never pops an empty queue.
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("token queue underflow");

	// A full-table result is an identifier numbered zero.
	a_full_is_ident: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_data.table_full |->
			tok_data.token_kind == lwin_pkg::KIND_IDENT && tok_data.token_value == '0)
		else $error("table_full on a non-identifier or nonzero value");

	// Operator tokens carry a valid index and no full flag.
	a_spec_range: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_data.token_kind == lwin_pkg::KIND_SPEC |->
			tok_data.token_value < 31'(lwin_pkg::OP_COUNT) && !tok_data.table_full)
		else $error("operator token out of range");
`endif

endmodule

FILE: tb/lexer_with_ident_numbering_unit_tb.sv
// Self-checking bench for lexer_with_ident_numbering_unit: random character streams in, tokens out.
// Depends on lwin_pkg and the RTL under rtl/core; needs no files or arguments.
`timescale 1ns / 1ps

module lexer_with_ident_numbering_unit_tb;

	localparam int          SLOTS        = 64;
	localparam int          CHAR_TARGET  = 1600;
	localparam int          STALL_LIMIT  = 5000;
	localparam int          DRAIN_CYCLES = 120;
	localparam int          POOL_SIZE    = 96;
	localparam int          NAME_MAX     = 20;
	localparam int          REPORT_MAX   = 10;
	// Operator characters in index order: position in this string is the SPEC value.
	localparam logic [47:0] OP_CHARS     = "+-*/()";
	localparam logic [7:0]  CH_SPACE     = 8'd32;
	localparam logic [7:0]  CH_COMMA     = 8'd44;
	localparam logic [7:0]  CH_PERIOD    = 8'd46;

	typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUM, SCAN_IDENT} scan_t;

	// Token predictor plus the queue of tokens still owed by the block.
	class lex_scoreboard;
		scan_t                 mode;
		logic [30:0]           number;
		logic [31:0]           hash;
		logic [31:0]           weight;
		logic [31:0]           known_hashes[SLOTS];
		int                    known_count;
		lwin_pkg::token_beat_t pending_tokens[$];
		lwin_pkg::token_beat_t fresh[$];
		int                    mismatches;

		function new();
			mode        = SCAN_IDLE;
			number      = '0;
			hash        = '0;
			weight      = 32'd1;
			known_count = 0;
			mismatches  = 0;
		endfunction

		function bit digit_char(logic [7:0] ch);
			return ch >= lwin_pkg::CH_ZERO && ch <= lwin_pkg::CH_NINE;
		endfunction

		function bit name_char(logic [7:0] ch);
			return ch >= lwin_pkg::CH_LET_LO && ch <= lwin_pkg::CH_LET_HI;
		endfunction

		function int op_slot(logic [7:0] ch);
			for (int i = 0; i < 6; i++)
				if (OP_CHARS[47 - 8*i -: 8] == ch)
					return i;
			return -1;
		endfunction

		function void push_token(logic [1:0] kind, logic [30:0] value, logic full);
			lwin_pkg::token_beat_t t;
			t.token_kind  = kind;
			t.token_value = value;
			t.table_full  = full;
			t.end_of_run  = 1'b0;
			fresh.push_back(t);
		endfunction

		function void fold_hash(logic [7:0] ch);
			logic [31:0] code;
			if (digit_char(ch))
				code = {24'd0, ch} - {24'd0, lwin_pkg::CH_ZERO};
			else
				code = {24'd0, ch} - lwin_pkg::LETTER_BIAS;
			hash   = hash + code * weight;
			weight = weight * lwin_pkg::HASH_BASE;
		endfunction

		function void close_token();
			int slot;
			slot = -1;
			if (mode == SCAN_NUM) begin
				push_token(lwin_pkg::KIND_CONST, number, 1'b0);
			end else if (mode == SCAN_IDENT) begin
				for (int i = 0; i < known_count; i++)
					if (slot < 0 && known_hashes[i] == hash)
						slot = i;
				if (slot >= 0) begin
					push_token(lwin_pkg::KIND_IDENT, 31'(slot), 1'b0);
				end else if (known_count < SLOTS) begin
					known_hashes[known_count] = hash;
					push_token(lwin_pkg::KIND_IDENT, 31'(known_count), 1'b0);
					known_count++;
				end else begin
					push_token(lwin_pkg::KIND_IDENT, '0, 1'b1);
				end
			end
			mode   = SCAN_IDLE;
			number = '0;
			hash   = '0;
			weight = 32'd1;
		endfunction

		function void open_token(logic [7:0] ch);
			int op;
			op = op_slot(ch);
			if (op >= 0) begin
				push_token(lwin_pkg::KIND_SPEC, 31'(op), 1'b0);
			end else if (digit_char(ch)) begin
				mode   = SCAN_NUM;
				number = 31'(ch - lwin_pkg::CH_ZERO);
			end else if (name_char(ch)) begin
				mode   = SCAN_IDENT;
				hash   = '0;
				weight = 32'd1;
				fold_hash(ch);
			end
		endfunction

		function void note_char(lwin_pkg::char_beat_t b);
			logic [7:0]            ch;
			logic [63:0]           grown;
			lwin_pkg::token_beat_t t;
			ch = b.char_code;
			fresh.delete();
			case (mode)
				SCAN_NUM: begin
					if (digit_char(ch)) begin
						grown  = 64'(number) * 64'd10 + 64'(ch - lwin_pkg::CH_ZERO);
						number = (grown > 64'(lwin_pkg::CONST_MAX)) ?
							lwin_pkg::CONST_MAX : grown[30:0];
					end else begin
						close_token();
						open_token(ch);
					end
				end
				SCAN_IDENT: begin
					if (digit_char(ch) || name_char(ch)) begin
						fold_hash(ch);
					end else begin
						close_token();
						open_token(ch);
					end
				end
				default: open_token(ch);
			endcase
			if (b.is_final)
				close_token();
			if (fresh.size() > 0) begin
				t = fresh.pop_back();
				t.end_of_run = 1'b1;
				fresh.push_back(t);
			end
			foreach (fresh[i])
				pending_tokens.push_back(fresh[i]);
		endfunction

		function void check_token(lwin_pkg::token_beat_t got);
			lwin_pkg::token_beat_t want;
			if (pending_tokens.size() == 0) begin
				if (mismatches < REPORT_MAX)
					$display("unexpected token: kind %0d value %0d full %0d last %0d",
						got.token_kind, got.token_value, got.table_full, got.end_of_run);
				mismatches++;
				return;
			end
			want = pending_tokens.pop_front();
			if (got !== want) begin
				if (mismatches < REPORT_MAX)
					$display({"token mismatch (expected/actual): ",
						"kind %0d/%0d value %0d/%0d full %0d/%0d last %0d/%0d"},
						want.token_kind, got.token_kind, want.token_value, got.token_value,
						want.table_full, got.table_full, want.end_of_run, got.end_of_run);
				mismatches++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  char_valid = 1'b0;
	logic                  char_ready;
	lwin_pkg::char_beat_t  char_data = '0;
	logic                  tok_valid;
	logic                  tok_ready = 1'b0;
	lwin_pkg::token_beat_t tok_data;

	lex_scoreboard sb = new();

	int send_idle_pct = 19;
	int recv_idle_pct = 86;
	int token_chars   = 0;
	int quiet_cycles  = 0;

	// Identifier pool: fixed names so that repeats hit the table and new ones fill it.
	logic [7:0] name_text[POOL_SIZE][NAME_MAX];
	int         name_len[POOL_SIZE];

	lexer_with_ident_numbering_unit #(
		.TABLE_DEPTH(SLOTS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_data (char_data),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_data  (tok_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: check each accepted token beat, then draw ready for the next edge.
	always @(posedge clk) begin
		if (arst_n && tok_valid && tok_ready)
			sb.check_token(tok_data);
		tok_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: count edges where neither channel moves a beat.
	always @(posedge clk) begin
		if ((char_valid && char_ready) || (tok_valid && tok_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic bit lucky(int pct);
		return $urandom_range(99) < pct;
	endfunction

	// Offer one character and hold it until accepted; idle before it at random.
	task automatic send_char(input logic [7:0] ch, input logic fin, input bit counts);
		lwin_pkg::char_beat_t b;
		b.char_code = ch;
		b.is_final  = fin;
		while (lucky(send_idle_pct)) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_data  <= b;
		@(posedge clk);
		while (!char_ready)
			@(posedge clk);
		sb.note_char(b);
		if (counts)
			token_chars++;
	endtask

	task automatic send_name(input int idx);
		for (int i = 0; i < name_len[idx]; i++)
			send_char(name_text[idx][i], (i == name_len[idx] - 1) ? lucky(6) : lucky(1), 1'b1);
	endtask

	task automatic send_number(input int digits);
		for (int i = 0; i < digits; i++)
			send_char(lwin_pkg::CH_ZERO + 8'($urandom_range(9)),
				(i == digits - 1) ? lucky(6) : lucky(1), 1'b1);
	endtask

	task automatic send_op();
		int i;
		i = $urandom_range(5);
		send_char(OP_CHARS[47 - 8*i -: 8], lucky(4), 1'b1);
	endtask

	// Break between tokens: blank, comma, period, operator or a raw byte.
	task automatic send_gap();
		case ($urandom_range(4))
			0: send_char(CH_SPACE, lucky(4), 1'b0);
			1: send_char(CH_COMMA, lucky(4), 1'b0);
			2: send_char(CH_PERIOD, lucky(4), 1'b0);
			3: send_op();
			default: send_char(8'($urandom_range(255)), lucky(10), 1'b0);
		endcase
	endtask

	initial begin
		int hi;

		// Build the name pool: mostly short names, every eighth one long.
		for (int p = 0; p < POOL_SIZE; p++) begin
			name_len[p] = (p % 8 == 7) ? $urandom_range(8, NAME_MAX) : $urandom_range(1, 5);
			name_text[p][0] = 8'($urandom_range(lwin_pkg::CH_LET_LO, lwin_pkg::CH_LET_HI));
			for (int i = 1; i < NAME_MAX; i++)
				name_text[p][i] = lucky(50) ?
					8'($urandom_range(lwin_pkg::CH_LET_LO, lwin_pkg::CH_LET_HI))
					: lwin_pkg::CH_ZERO + 8'($urandom_range(9));
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: ignored characters, byte extremes, every operator.
		send_char(CH_COMMA, 1'b0, 1'b0);
		send_char(CH_PERIOD, 1'b0, 1'b0);
		send_char(8'h00, 1'b0, 1'b0);
		send_char(8'hFF, 1'b1, 1'b0);
		for (int i = 0; i < 6; i++)
			send_char(OP_CHARS[47 - 8*i -: 8], 1'b0, 1'b1);
		// Saturating constant whose last digit carries the final mark.
		for (int i = 0; i < 10; i++)
			send_char(lwin_pkg::CH_NINE, i == 9, 1'b1);
		// Identifier spanning the letter extremes and a digit, ended by an operator:
		// the '+' closes the name and makes its own token in the same beat.
		send_char(lwin_pkg::CH_LET_LO, 1'b0, 1'b1);
		send_char(lwin_pkg::CH_LET_HI, 1'b0, 1'b1);
		send_char(lwin_pkg::CH_NINE, 1'b0, 1'b1);
		send_char(lwin_pkg::CH_PLUS, 1'b0, 1'b1);
		send_char(lwin_pkg::CH_ZERO, 1'b1, 1'b1);

		// Random stream; widen the name range as it goes so that the table fills.
		while (token_chars < CHAR_TARGET) begin
			if (token_chars < CHAR_TARGET / 3) begin
				send_idle_pct = 19;
				recv_idle_pct = 86;
			end else if (token_chars < 2 * CHAR_TARGET / 3) begin
				send_idle_pct = 86;
				recv_idle_pct = 19;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			hi = 8 + token_chars * 2 * POOL_SIZE / CHAR_TARGET;
			if (hi > POOL_SIZE - 1)
				hi = POOL_SIZE - 1;
			case ($urandom_range(9))
				0, 1, 2, 3: send_name($urandom_range(hi));
				4, 5, 6:    send_number(lucky(10) ? $urandom_range(9, 12) : $urandom_range(1, 4));
				7:          send_op();
				8:          send_char(8'($urandom_range(255)), lucky(10), 1'b0);
				default:    send_gap();
			endcase
			if (lucky(60))
				send_gap();
		end
		char_valid <= 1'b0;

		// Drain: wait for every owed token, then watch for strays.
		while (sb.pending_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending_tokens.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/lwin_pkg.sv
rtl/core/lwin_ram.sv
rtl/core/lwin_front.sv
rtl/core/lwin_fifo.sv
rtl/core/lwin_back.sv
rtl/core/lexer_with_ident_numbering_unit.sv
tb/lexer_with_ident_numbering_unit_tb.sv
